// ===== src/qrbs_pkg.sv =====
// shared types, constants and step tables for the quadrotor rigid body step
`default_nettype none
package qrbs_pkg;

    // default number format
    localparam int DEF_WORD_BITS     = 32;
    localparam int DEF_FRACTION_BITS = 16;

    // configuration register indexes
    localparam logic [2:0] REG_INV_MASS  = 3'd0;
    localparam logic [2:0] REG_INV_INER_X = 3'd1;
    localparam logic [2:0] REG_INV_INER_Y = 3'd2;
    localparam logic [2:0] REG_INV_INER_Z = 3'd3;
    localparam logic [2:0] REG_GRAVITY   = 3'd4;
    localparam logic [2:0] REG_TIME_STEP = 3'd5;

    // register reset values
    localparam logic [30:0] RST_INV_MASS   = 31'd61479;
    localparam logic [30:0] RST_INV_INER_X = 31'd568889;
    localparam logic [30:0] RST_INV_INER_Y = 31'd568889;
    localparam logic [30:0] RST_INV_INER_Z = 31'd300623;
    localparam logic [31:0] RST_GRAVITY    = 32'hFFF6_317E;
    localparam logic [30:0] RST_TIME_STEP  = 31'd328;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ANG,
        PH_DERIV,
        PH_QTRAP,
        PH_NORM,
        PH_DIV,
        PH_SQRT,
        PH_SCALE,
        PH_AXIS,
        PH_FM,
        PH_LIN,
        PH_POSE,
        PH_TWIST
    } phase_t;

    // one product term of the quaternion derivative
    typedef struct packed {
        logic [1:0] qi;   // quaternion component
        logic [1:0] j;    // body rate, also term position
        logic [1:0] k;    // derivative component
        logic       neg;
    } deriv_op_t;

    // one product term of the thrust axis
    typedef struct packed {
        logic [1:0] qa;
        logic [1:0] qb;
        logic [1:0] dest;
        logic       neg;
        logic       first;
        logic       last;
        logic       dbl;
    } axis_op_t;

    // quaternion derivative terms, w=0 x=1 y=2 z=3
    function automatic deriv_op_t deriv_op(input logic [3:0] n);
        deriv_op_t op;
        op = '0;
        case (n)
            4'd0:  op = '{qi: 2'd1, j: 2'd0, k: 2'd0, neg: 1'b1};
            4'd1:  op = '{qi: 2'd2, j: 2'd1, k: 2'd0, neg: 1'b1};
            4'd2:  op = '{qi: 2'd3, j: 2'd2, k: 2'd0, neg: 1'b1};
            4'd3:  op = '{qi: 2'd0, j: 2'd0, k: 2'd1, neg: 1'b0};
            4'd4:  op = '{qi: 2'd3, j: 2'd1, k: 2'd1, neg: 1'b1};
            4'd5:  op = '{qi: 2'd2, j: 2'd2, k: 2'd1, neg: 1'b0};
            4'd6:  op = '{qi: 2'd3, j: 2'd0, k: 2'd2, neg: 1'b0};
            4'd7:  op = '{qi: 2'd0, j: 2'd1, k: 2'd2, neg: 1'b0};
            4'd8:  op = '{qi: 2'd1, j: 2'd2, k: 2'd2, neg: 1'b1};
            4'd9:  op = '{qi: 2'd2, j: 2'd0, k: 2'd3, neg: 1'b1};
            4'd10: op = '{qi: 2'd1, j: 2'd1, k: 2'd3, neg: 1'b0};
            4'd11: op = '{qi: 2'd0, j: 2'd2, k: 2'd3, neg: 1'b0};
            default: op = '0;
        endcase
        return op;
    endfunction

    // thrust axis terms
    function automatic axis_op_t axis_op(input logic [2:0] n);
        axis_op_t op;
        op = '0;
        case (n)
            3'd0: op = '{qa: 2'd0, qb: 2'd2, dest: 2'd0, neg: 1'b0, first: 1'b1,
                         last: 1'b0, dbl: 1'b0};
            3'd1: op = '{qa: 2'd1, qb: 2'd3, dest: 2'd0, neg: 1'b0, first: 1'b0,
                         last: 1'b1, dbl: 1'b1};
            3'd2: op = '{qa: 2'd2, qb: 2'd3, dest: 2'd1, neg: 1'b0, first: 1'b1,
                         last: 1'b0, dbl: 1'b0};
            3'd3: op = '{qa: 2'd0, qb: 2'd1, dest: 2'd1, neg: 1'b1, first: 1'b0,
                         last: 1'b1, dbl: 1'b1};
            3'd4: op = '{qa: 2'd0, qb: 2'd0, dest: 2'd2, neg: 1'b0, first: 1'b1,
                         last: 1'b0, dbl: 1'b0};
            3'd5: op = '{qa: 2'd1, qb: 2'd1, dest: 2'd2, neg: 1'b1, first: 1'b0,
                         last: 1'b0, dbl: 1'b0};
            3'd6: op = '{qa: 2'd2, qb: 2'd2, dest: 2'd2, neg: 1'b1, first: 1'b0,
                         last: 1'b0, dbl: 1'b0};
            default: op = '{qa: 2'd3, qb: 2'd3, dest: 2'd2, neg: 1'b0, first: 1'b0,
                            last: 1'b1, dbl: 1'b0};
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

// ===== src/quadrotor_rigid_body_step.sv =====
// Each tick runs from the input transaction to the pose and twist records; the default
// format is Q16.16. When the norm is not positive the divide, root and scale steps are skipped.
// One tick at a time; the next tick can be taken in the cycle after the twist transaction.
// Rate is set by the single shared multiplier and the bit-serial divide and root steps.
// Reset (rst_n low, asynchronous): registers to defaults, state zero, attitude identity.
`default_nettype none
module quadrotor_rigid_body_step #(
    parameter int WORD_BITS     = qrbs_pkg::DEF_WORD_BITS,
    parameter int FRACTION_BITS = qrbs_pkg::DEF_FRACTION_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // thrust_force, torque_roll, torque_pitch, torque_yaw
    input  wire logic [127:0] s_axis_tdata,
    // output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // value_a, value_b, value_c, value_d, value_e, value_f, value_g
    output logic [223:0]      m_axis_tdata,
    // record_kind
    output logic              m_axis_tuser,
    // last_of_step
    output logic              m_axis_tlast
);
    import qrbs_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int QB  = 3 * F + 1;
    localparam int SI  = (QB + 1) / 2;
    localparam int QE  = 2 * SI;
    localparam int MW0 = (W > 32) ? W : 32;
    localparam int MW  = (MW0 > SI + 1) ? MW0 : SI + 1;
    localparam int PW  = 2 * MW;
    localparam int CW  = $clog2(QB + 1);
    localparam logic signed [W-1:0] ONE_W = W'(1) << F;

    typedef logic signed [W-1:0] word_t;

    function automatic word_t halve(input word_t x);
        return x >>> 1;
    endfunction

    // configuration registers
    logic [30:0] inv_mass_reg, inv_ix_reg, inv_iy_reg, inv_iz_reg, dt_reg;
    logic [31:0] grav_reg;

    // integrator state
    phase_t phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0] sub_reg, sub_next;
    word_t ang_acc_reg [3], ang_acc_next [3];
    word_t ang_rate_reg [3], ang_rate_next [3];
    word_t quat_reg [4], quat_next [4];
    word_t qrate_reg [4], qrate_next [4];
    word_t lin_acc_reg [3], lin_acc_next [3];
    word_t vel_reg [3], vel_next [3];
    word_t pos_reg [3], pos_next [3];

    // working registers
    word_t thr_reg, thr_next;
    word_t tq_reg [3], tq_next [3];
    word_t t_reg, t_next;
    word_t acc_reg, acc_next;
    word_t dq_reg [4], dq_next [4];
    word_t ax_reg [3], ax_next [3];
    word_t fm_reg, fm_next;
    word_t vold_reg, vold_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [QE-1:0] q_reg, q_next;
    logic [SI+1:0] sr_reg, sr_next;
    logic [SI-1:0] root_reg, root_next;

    // shared multiplier
    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] prod_full;
    word_t prod;

    assign prod_full = ma * mb;
    assign prod      = prod_full[F +: W];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg <= RST_INV_MASS;
            inv_ix_reg   <= RST_INV_INER_X;
            inv_iy_reg   <= RST_INV_INER_Y;
            inv_iz_reg   <= RST_INV_INER_Z;
            grav_reg     <= RST_GRAVITY;
            dt_reg       <= RST_TIME_STEP;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_INV_MASS:   inv_mass_reg <= cfg_wdata[30:0];
                REG_INV_INER_X: inv_ix_reg   <= cfg_wdata[30:0];
                REG_INV_INER_Y: inv_iy_reg   <= cfg_wdata[30:0];
                REG_INV_INER_Z: inv_iz_reg   <= cfg_wdata[30:0];
                REG_GRAVITY:    grav_reg     <= cfg_wdata;
                REG_TIME_STEP:  dt_reg       <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // sequencer and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            sub_reg      <= '0;
            ang_acc_reg  <= '{default: '0};
            ang_rate_reg <= '{default: '0};
            quat_reg     <= '{ONE_W, '0, '0, '0};
            qrate_reg    <= '{default: '0};
            lin_acc_reg  <= '{default: '0};
            vel_reg      <= '{default: '0};
            pos_reg      <= '{default: '0};
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            sub_reg      <= sub_next;
            ang_acc_reg  <= ang_acc_next;
            ang_rate_reg <= ang_rate_next;
            quat_reg     <= quat_next;
            qrate_reg    <= qrate_next;
            lin_acc_reg  <= lin_acc_next;
            vel_reg      <= vel_next;
            pos_reg      <= pos_next;
        end
    end

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        thr_reg  <= thr_next;
        tq_reg   <= tq_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        dq_reg   <= dq_next;
        ax_reg   <= ax_next;
        fm_reg   <= fm_next;
        vold_reg <= vold_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        sr_reg   <= sr_next;
        root_reg <= root_next;
    end

    // next state and datapath control
    always_comb
    begin
        logic [1:0]    i;
        logic [30:0]   inv_sel;
        word_t         sum;
        word_t         term;
        word_t         base;
        word_t         grav_w;
        deriv_op_t     dop;
        axis_op_t      aop;
        logic [W:0]    rem_s;
        logic [SI+3:0] r4;
        logic [SI+3:0] trial;

        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        sub_next      = sub_reg;
        ang_acc_next  = ang_acc_reg;
        ang_rate_next = ang_rate_reg;
        quat_next     = quat_reg;
        qrate_next    = qrate_reg;
        lin_acc_next  = lin_acc_reg;
        vel_next      = vel_reg;
        pos_next      = pos_reg;
        thr_next      = thr_reg;
        tq_next       = tq_reg;
        t_next        = t_reg;
        acc_next      = acc_reg;
        dq_next       = dq_reg;
        ax_next       = ax_reg;
        fm_next       = fm_reg;
        vold_next     = vold_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        sr_next       = sr_reg;
        root_next     = root_reg;

        ma      = '0;
        mb      = '0;
        i       = cnt_reg[1:0];
        inv_sel = (i == 2'd0) ? inv_ix_reg : ((i == 2'd1) ? inv_iy_reg : inv_iz_reg);
        sum     = '0;
        term    = '0;
        base    = '0;
        grav_w  = W'(signed'(grav_reg));
        dop     = deriv_op(cnt_reg[3:0]);
        aop     = axis_op(cnt_reg[2:0]);
        rem_s   = {rem_reg, (cnt_reg == '0)};
        r4      = {sr_reg, q_reg[QE-1 -: 2]};
        trial   = (SI+4)'({root_reg, 2'b01});

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    thr_next   = W'(signed'(s_axis_tdata[31:0]));
                    tq_next[0] = W'(signed'(s_axis_tdata[63:32]));
                    tq_next[1] = W'(signed'(s_axis_tdata[95:64]));
                    tq_next[2] = W'(signed'(s_axis_tdata[127:96]));
                    phase_next = PH_ANG;
                    cnt_next   = '0;
                    sub_next   = '0;
                end
            end

            // angular acceleration, then trapezoid on the body rate
            PH_ANG:
            begin
                if (sub_reg == 2'd0)
                begin
                    ma       = MW'(inv_sel);
                    mb       = MW'(tq_reg[i]);
                    t_next   = prod;
                    sub_next = 2'd1;
                end
                else
                begin
                    sum              = t_reg + ang_acc_reg[i];
                    ma               = MW'(dt_reg);
                    mb               = MW'(sum);
                    ang_rate_next[i] = ang_rate_reg[i] + halve(prod);
                    ang_acc_next[i]  = t_reg;
                    sub_next         = 2'd0;
                    if (i == 2'd2)
                    begin
                        phase_next = PH_DERIV;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            // quaternion derivative, three products per component
            PH_DERIV:
            begin
                ma   = MW'(quat_reg[dop.qi]);
                mb   = MW'(ang_rate_reg[dop.j]);
                term = dop.neg ? -prod : prod;
                base = (dop.j == 2'd0) ? '0 : acc_reg;
                sum  = base + term;
                if (dop.j == 2'd2)
                    dq_next[dop.k] = halve(sum);
                else
                    acc_next = sum;
                if (cnt_reg == CW'(11))
                begin
                    phase_next = PH_QTRAP;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // trapezoid on the attitude
            PH_QTRAP:
            begin
                sum           = dq_reg[i] + qrate_reg[i];
                ma            = MW'(dt_reg);
                mb            = MW'(sum);
                quat_next[i]  = quat_reg[i] + halve(prod);
                qrate_next[i] = dq_reg[i];
                if (i == 2'd3)
                begin
                    phase_next = PH_NORM;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // squared norm, skip renormalizing when not positive
            PH_NORM:
            begin
                ma       = MW'(quat_reg[i]);
                mb       = MW'(quat_reg[i]);
                base     = (i == 2'd0) ? '0 : acc_reg;
                sum      = base + prod;
                acc_next = sum;
                cnt_next = cnt_reg + 1'b1;
                if (i == 2'd3)
                begin
                    cnt_next  = '0;
                    rem_next  = '0;
                    q_next    = '0;
                    if (sum == '0 || sum[W-1])
                        phase_next = PH_AXIS;
                    else
                        phase_next = PH_DIV;
                end
            end

            // restoring division of 2^(3F) by the norm, one bit a cycle
            PH_DIV:
            begin
                if (rem_s >= {1'b0, acc_reg})
                begin
                    rem_next = W'(rem_s - {1'b0, acc_reg});
                    q_next   = {q_reg[QE-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_s[W-1:0];
                    q_next   = {q_reg[QE-2:0], 1'b0};
                end
                if (cnt_reg == CW'(QB - 1))
                begin
                    phase_next = PH_SQRT;
                    cnt_next   = '0;
                    sr_next    = '0;
                    root_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // integer square root, two quotient bits a cycle
            PH_SQRT:
            begin
                q_next = q_reg << 2;
                if (r4 >= trial)
                begin
                    sr_next   = (SI+2)'(r4 - trial);
                    root_next = {root_reg[SI-2:0], 1'b1};
                end
                else
                begin
                    sr_next   = r4[SI+1:0];
                    root_next = {root_reg[SI-2:0], 1'b0};
                end
                if (cnt_reg == CW'(SI - 1))
                begin
                    phase_next = PH_SCALE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // scale each component by the reciprocal root
            PH_SCALE:
            begin
                ma           = MW'(quat_reg[i]);
                mb           = MW'(root_reg);
                quat_next[i] = prod;
                if (i == 2'd3)
                begin
                    phase_next = PH_AXIS;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // body z axis in world frame
            PH_AXIS:
            begin
                ma   = MW'(quat_reg[aop.qa]);
                mb   = MW'(quat_reg[aop.qb]);
                term = aop.neg ? -prod : prod;
                base = aop.first ? '0 : acc_reg;
                sum  = base + term;
                if (aop.last)
                    ax_next[aop.dest] = aop.dbl ? (sum <<< 1) : sum;
                else
                    acc_next = sum;
                if (cnt_reg == CW'(7))
                begin
                    phase_next = PH_FM;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // thrust per mass
            PH_FM:
            begin
                ma         = MW'(thr_reg);
                mb         = MW'(inv_mass_reg);
                fm_next    = prod;
                phase_next = PH_LIN;
                cnt_next   = '0;
                sub_next   = '0;
            end

            // linear acceleration, velocity and position per axis
            PH_LIN:
            begin
                if (sub_reg == 2'd0)
                begin
                    ma       = MW'(ax_reg[i]);
                    mb       = MW'(fm_reg);
                    t_next   = (i == 2'd2) ? (prod + grav_w) : prod;
                    sub_next = 2'd1;
                end
                else if (sub_reg == 2'd1)
                begin
                    sum             = t_reg + lin_acc_reg[i];
                    ma              = MW'(dt_reg);
                    mb              = MW'(sum);
                    vel_next[i]     = vel_reg[i] + halve(prod);
                    lin_acc_next[i] = t_reg;
                    vold_next       = vel_reg[i];
                    sub_next        = 2'd2;
                end
                else
                begin
                    sum         = vel_reg[i] + vold_reg;
                    ma          = MW'(dt_reg);
                    mb          = MW'(sum);
                    pos_next[i] = pos_reg[i] + halve(prod);
                    sub_next    = 2'd0;
                    if (i == 2'd2)
                    begin
                        phase_next = PH_POSE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            PH_POSE:
            begin
                if (m_axis_tready)
                    phase_next = PH_TWIST;
            end

            PH_TWIST:
            begin
                if (m_axis_tready)
                    phase_next = PH_IDLE;
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // stream outputs
    assign s_axis_tready = (phase_reg == PH_IDLE);
    assign m_axis_tvalid = (phase_reg == PH_POSE) || (phase_reg == PH_TWIST);
    assign m_axis_tuser  = (phase_reg == PH_TWIST);
    assign m_axis_tlast  = (phase_reg == PH_TWIST);

    always_comb
    begin
        if (phase_reg == PH_TWIST)
            m_axis_tdata = {32'd0,
                            32'(ang_rate_reg[2]), 32'(ang_rate_reg[1]), 32'(ang_rate_reg[0]),
                            32'(vel_reg[2]), 32'(vel_reg[1]), 32'(vel_reg[0])};
        else
            m_axis_tdata = {32'(quat_reg[0]),
                            32'(quat_reg[3]), 32'(quat_reg[2]), 32'(quat_reg[1]),
                            32'(pos_reg[2]), 32'(pos_reg[1]), 32'(pos_reg[0])};
    end

endmodule
`default_nettype wire

// ===== src/qrbs_checker.sv =====
// port-level checks for the quadrotor rigid body step, bound to the top level
`default_nettype none
module qrbs_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tuser,
    input wire logic m_axis_tlast
);

    // the twist record is the last one of a tick
    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("record kind and last flag disagree");

    // no new tick while results are pending
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while results pending");

    // input transaction starts work
    a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after input transaction");

    // pose transaction is followed by the twist record
    a_pose_twist: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tlast))
        else $error("twist record missing after pose");

    // twist transaction ends the tick
    a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("extra record after twist");

endmodule

bind quadrotor_rigid_body_step qrbs_checker u_qrbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
